@@ design/c65eu_pkg.sv @@
// Shared constants, opcode codes and types of the 6502 execute unit.
package c65eu_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int APB_AW      = 4;

    localparam logic [APB_AW-1:0] ADDR_RESET_VEC = 4'h0;
    localparam logic [APB_AW-1:0] ADDR_IRQ_VEC   = 4'h4;
    localparam logic [APB_AW-1:0] ADDR_NMI_VEC   = 4'h8;

    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    localparam logic [1:0] MODE_IMM = 2'd1;
    localparam logic [1:0] MODE_ACC = 2'd2;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
        OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
        OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
        OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
        OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
        OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
        OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
        OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
        OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
        OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
        OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
        OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
        OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
        OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
    } opcode_t;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  opcode;
        logic [1:0]  mode_sel;
        logic [7:0]  operand_value;
        logic [15:0] operand_address;
        logic [1:0]  inst_size;
    } req_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  status_out;
        logic [7:0]  sp_out;
        logic        mem_write;
        logic [15:0] write_address;
        logic [7:0]  write_data;
    } res_t;

    // One stack memory access issued by the sequencer
    typedef struct packed {
        logic            wr_en;
        logic            rd_en;
        logic [SP_W-1:0] addr;
        logic [7:0]      wdata;
    } stk_cmd_t;

    function automatic logic [7:0] set_nz(input logic [7:0] sr, input logic [7:0] v);
        logic [7:0] s;
        s = sr & ~(FLAG_N | FLAG_Z);
        if (v[7])
        begin
            s = s | FLAG_N;
        end
        if (v == 8'h00)
        begin
            s = s | FLAG_Z;
        end
        return s;
    endfunction

endpackage

@@ design/c65eu_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface c65eu_req_if;
    logic              valid;
    logic              ready;
    c65eu_pkg::req_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface c65eu_res_if;
    logic              valid;
    logic              ready;
    c65eu_pkg::res_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/c65eu_stack_ram.sv @@
// 256-byte stack store, one write or one registered read per cycle.
module c65eu_stack_ram
(
    input  logic                       clk,
    input  c65eu_pkg::stk_cmd_t        cmd,
    output logic [7:0]                 rdata
);

    logic [7:0] mem [c65eu_pkg::STACK_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/c65eu_core.sv @@
// Instruction sequencer: register file, ALU, stack access steps and result register.
module c65eu_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    c65eu_req_if.sink              req,
    c65eu_res_if.source            res,
    input  logic                   pc_load,
    input  logic [15:0]            pc_load_value,
    input  logic [15:0]            irq_vector,
    input  logic [15:0]            nmi_vector,
    output c65eu_pkg::stk_cmd_t    stk_cmd,
    input  logic [7:0]             stk_rdata
);

    typedef enum logic [1:0] { S_RUN, S_STEP1, S_STEP2, S_STEP3 } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  a_reg, a_next, x_reg, x_next, y_reg, y_next;
    logic [7:0]  p_reg, p_next, sp_reg, sp_next;
    logic [15:0] pc_reg, pc_next;
    c65eu_pkg::req_t cur_reg, cur_next;
    logic [7:0]  lo_reg, lo_next;
    logic        rvalid_reg, rvalid_next;
    c65eu_pkg::res_t rdata_reg, rdata_next;

    logic        accept, slot_free;
    logic        emit;
    c65eu_pkg::stk_cmd_t cmd;

    assign slot_free = !rvalid_reg || res.ready;
    assign req.ready = (state_reg == S_RUN) && slot_free;
    assign accept    = req.valid && req.ready;
    assign res.valid   = rvalid_reg;
    assign res.payload = rdata_reg;
    assign stk_cmd = cmd;

    always_comb
    begin
        logic [7:0]  m, v, r;
        logic [8:0]  sum;
        logic        take, branch;
        logic [15:0] seq, t;
        logic [5:0]  op;
        c65eu_pkg::req_t q;

        state_next = state_reg;
        a_next = a_reg; x_next = x_reg; y_next = y_reg;
        p_next = p_reg; sp_next = sp_reg; pc_next = pc_reg;
        cur_next = cur_reg; lo_next = lo_reg;
        rvalid_next = rvalid_reg && !res.ready;
        rdata_next = rdata_reg;
        cmd = '0;
        emit = 1'b0;
        m = 8'h00; v = 8'h00; r = 8'h00; sum = 9'h000;
        take = 1'b0; branch = 1'b0; t = 16'h0000;
        q = (state_reg == S_RUN) ? req.payload : cur_reg;
        op = q.opcode;
        seq = pc_reg + {14'h0000, q.inst_size};
        rdata_next.mem_write     = 1'b0;

        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    cur_next = q;
                    m = q.operand_value;
                    emit = 1'b1;
                    pc_next = seq;
                    rdata_next.mem_write = 1'b0;
                    rdata_next.write_address = 16'h0000;
                    rdata_next.write_data = 8'h00;
                    if (q.req_type)
                    begin
                        // NMI: push PCH now, PCL and status follow
                        lo_next = pc_reg[7:0];
                        cmd = '{1'b1, 1'b0, sp_reg, pc_reg[15:8]};
                        sp_next = sp_reg - 8'd1;
                        emit = 1'b0;
                        state_next = S_STEP1;
                    end
                    else
                    begin
                        case (op)
                            c65eu_pkg::OP_ADC, c65eu_pkg::OP_SBC:
                            begin
                                v = (op == c65eu_pkg::OP_SBC) ? ~m : m;
                                sum = {1'b0, a_reg} + {1'b0, v} + {8'h00, p_reg[0]};
                                r = sum[7:0];
                                p_next = c65eu_pkg::set_nz(p_reg, r);
                                p_next[0] = sum[8];
                                p_next[6] = ~(a_reg[7] ^ v[7]) & (a_reg[7] ^ r[7]);
                                a_next = r;
                            end
                            c65eu_pkg::OP_AND:
                            begin
                                a_next = a_reg & m;
                                p_next = c65eu_pkg::set_nz(p_reg, a_next);
                            end
                            c65eu_pkg::OP_ORA:
                            begin
                                a_next = a_reg | m;
                                p_next = c65eu_pkg::set_nz(p_reg, a_next);
                            end
                            c65eu_pkg::OP_EOR:
                            begin
                                a_next = a_reg ^ m;
                                p_next = c65eu_pkg::set_nz(p_reg, a_next);
                            end
                            c65eu_pkg::OP_ASL, c65eu_pkg::OP_LSR,
                            c65eu_pkg::OP_ROL, c65eu_pkg::OP_ROR:
                            begin
                                v = (q.mode_sel == c65eu_pkg::MODE_ACC) ? a_reg : m;
                                case (op)
                                    c65eu_pkg::OP_ASL: r = {v[6:0], 1'b0};
                                    c65eu_pkg::OP_LSR: r = {1'b0, v[7:1]};
                                    c65eu_pkg::OP_ROL: r = {v[6:0], p_reg[0]};
                                    default:           r = {p_reg[0], v[7:1]};
                                endcase
                                p_next = c65eu_pkg::set_nz(p_reg, r);
                                p_next[0] = (op == c65eu_pkg::OP_ASL ||
                                             op == c65eu_pkg::OP_ROL) ? v[7] : v[0];
                                if (q.mode_sel == c65eu_pkg::MODE_ACC)
                                begin
                                    a_next = r;
                                end
                                else
                                begin
                                    rdata_next.mem_write = 1'b1;
                                    rdata_next.write_address = q.operand_address;
                                    rdata_next.write_data = r;
                                end
                            end
                            c65eu_pkg::OP_BCC: begin branch = 1'b1; take = !p_reg[0]; end
                            c65eu_pkg::OP_BCS: begin branch = 1'b1; take = p_reg[0]; end
                            c65eu_pkg::OP_BEQ: begin branch = 1'b1; take = p_reg[1]; end
                            c65eu_pkg::OP_BNE: begin branch = 1'b1; take = !p_reg[1]; end
                            c65eu_pkg::OP_BMI: begin branch = 1'b1; take = p_reg[7]; end
                            c65eu_pkg::OP_BPL: begin branch = 1'b1; take = !p_reg[7]; end
                            c65eu_pkg::OP_BVC: begin branch = 1'b1; take = !p_reg[6]; end
                            c65eu_pkg::OP_BVS: begin branch = 1'b1; take = p_reg[6]; end
                            c65eu_pkg::OP_BIT:
                            begin
                                p_next = (p_reg & ~(c65eu_pkg::FLAG_N | c65eu_pkg::FLAG_V |
                                          c65eu_pkg::FLAG_Z)) |
                                         (m & (c65eu_pkg::FLAG_N | c65eu_pkg::FLAG_V));
                                p_next[1] = ((m & a_reg) == 8'h00);
                            end
                            c65eu_pkg::OP_BRK:
                            begin
                                t = pc_reg + 16'd2;
                                p_next = p_reg | c65eu_pkg::FLAG_B;
                                lo_next = t[7:0];
                                cmd = '{1'b1, 1'b0, sp_reg, t[15:8]};
                                sp_next = sp_reg - 8'd1;
                                emit = 1'b0;
                                state_next = S_STEP1;
                            end
                            c65eu_pkg::OP_CLC: p_next = p_reg & ~c65eu_pkg::FLAG_C;
                            c65eu_pkg::OP_CLD: p_next = p_reg & ~c65eu_pkg::FLAG_D;
                            c65eu_pkg::OP_CLI: p_next = p_reg & ~c65eu_pkg::FLAG_I;
                            c65eu_pkg::OP_CLV: p_next = p_reg & ~c65eu_pkg::FLAG_V;
                            c65eu_pkg::OP_SEC: p_next = p_reg | c65eu_pkg::FLAG_C;
                            c65eu_pkg::OP_SED: p_next = p_reg | c65eu_pkg::FLAG_D;
                            c65eu_pkg::OP_SEI: p_next = p_reg | c65eu_pkg::FLAG_I;
                            c65eu_pkg::OP_CMP, c65eu_pkg::OP_CPX, c65eu_pkg::OP_CPY:
                            begin
                                v = (op == c65eu_pkg::OP_CMP) ? a_reg :
                                    (op == c65eu_pkg::OP_CPX) ? x_reg : y_reg;
                                r = v - m;
                                p_next = c65eu_pkg::set_nz(p_reg, r);
                                p_next[0] = (v >= m);
                            end
                            c65eu_pkg::OP_DEC, c65eu_pkg::OP_INC:
                            begin
                                r = (op == c65eu_pkg::OP_DEC) ? m - 8'd1 : m + 8'd1;
                                p_next = c65eu_pkg::set_nz(p_reg, r);
                                rdata_next.mem_write = 1'b1;
                                rdata_next.write_address = q.operand_address;
                                rdata_next.write_data = r;
                            end
                            c65eu_pkg::OP_DEX:
                            begin
                                x_next = x_reg - 8'd1;
                                p_next = c65eu_pkg::set_nz(p_reg, x_next);
                            end
                            c65eu_pkg::OP_DEY:
                            begin
                                y_next = y_reg - 8'd1;
                                p_next = c65eu_pkg::set_nz(p_reg, y_next);
                            end
                            c65eu_pkg::OP_INX:
                            begin
                                x_next = x_reg + 8'd1;
                                p_next = c65eu_pkg::set_nz(p_reg, x_next);
                            end
                            c65eu_pkg::OP_INY:
                            begin
                                y_next = y_reg + 8'd1;
                                p_next = c65eu_pkg::set_nz(p_reg, y_next);
                            end
                            c65eu_pkg::OP_JMP: pc_next = q.operand_address;
                            c65eu_pkg::OP_JSR:
                            begin
                                t = seq - 16'd1;
                                lo_next = t[7:0];
                                cmd = '{1'b1, 1'b0, sp_reg, t[15:8]};
                                sp_next = sp_reg - 8'd1;
                                emit = 1'b0;
                                state_next = S_STEP1;
                            end
                            c65eu_pkg::OP_LDA:
                            begin
                                a_next = m;
                                p_next = c65eu_pkg::set_nz(p_reg, m);
                            end
                            c65eu_pkg::OP_LDX:
                            begin
                                x_next = m;
                                p_next = c65eu_pkg::set_nz(p_reg, m);
                            end
                            c65eu_pkg::OP_LDY:
                            begin
                                y_next = m;
                                p_next = c65eu_pkg::set_nz(p_reg, m);
                            end
                            c65eu_pkg::OP_PHA:
                            begin
                                cmd = '{1'b1, 1'b0, sp_reg, a_reg};
                                sp_next = sp_reg - 8'd1;
                            end
                            c65eu_pkg::OP_PHP:
                            begin
                                cmd = '{1'b1, 1'b0, sp_reg, p_reg | c65eu_pkg::FLAG_B};
                                sp_next = sp_reg - 8'd1;
                            end
                            c65eu_pkg::OP_PLA, c65eu_pkg::OP_PLP, c65eu_pkg::OP_RTI,
                            c65eu_pkg::OP_RTS:
                            begin
                                // pull: pre-increment and read, data lands next cycle
                                sp_next = sp_reg + 8'd1;
                                cmd = '{1'b0, 1'b1, sp_next, 8'h00};
                                emit = 1'b0;
                                state_next = S_STEP1;
                            end
                            c65eu_pkg::OP_STA, c65eu_pkg::OP_STX, c65eu_pkg::OP_STY:
                            begin
                                rdata_next.mem_write = 1'b1;
                                rdata_next.write_address = q.operand_address;
                                rdata_next.write_data =
                                    (op == c65eu_pkg::OP_STA) ? a_reg :
                                    (op == c65eu_pkg::OP_STX) ? x_reg : y_reg;
                            end
                            c65eu_pkg::OP_TAX:
                            begin
                                x_next = a_reg;
                                p_next = c65eu_pkg::set_nz(p_reg, a_reg);
                            end
                            c65eu_pkg::OP_TAY:
                            begin
                                y_next = a_reg;
                                p_next = c65eu_pkg::set_nz(p_reg, a_reg);
                            end
                            c65eu_pkg::OP_TSX:
                            begin
                                x_next = sp_reg;
                                p_next = c65eu_pkg::set_nz(p_reg, sp_reg);
                            end
                            c65eu_pkg::OP_TXA:
                            begin
                                a_next = x_reg;
                                p_next = c65eu_pkg::set_nz(p_reg, x_reg);
                            end
                            c65eu_pkg::OP_TXS: sp_next = x_reg;
                            c65eu_pkg::OP_TYA:
                            begin
                                a_next = y_reg;
                                p_next = c65eu_pkg::set_nz(p_reg, y_reg);
                            end
                            default: ;
                        endcase
                        if (branch && take)
                        begin
                            pc_next = seq + {{8{m[7]}}, m};
                        end
                    end
                end
            end

            S_STEP1:
            begin
                op = cur_reg.opcode;
                if (cur_reg.req_type || op == c65eu_pkg::OP_BRK)
                begin
                    cmd = '{1'b1, 1'b0, sp_reg, lo_reg};
                    sp_next = sp_reg - 8'd1;
                    state_next = S_STEP2;
                end
                else if (op == c65eu_pkg::OP_JSR)
                begin
                    cmd = '{1'b1, 1'b0, sp_reg, lo_reg};
                    sp_next = sp_reg - 8'd1;
                    pc_next = cur_reg.operand_address;
                    emit = 1'b1;
                    state_next = S_RUN;
                end
                else if (op == c65eu_pkg::OP_PLA)
                begin
                    a_next = stk_rdata;
                    p_next = c65eu_pkg::set_nz(p_reg, stk_rdata);
                    emit = 1'b1;
                    state_next = S_RUN;
                end
                else if (op == c65eu_pkg::OP_PLP)
                begin
                    p_next = stk_rdata;
                    emit = 1'b1;
                    state_next = S_RUN;
                end
                else if (op == c65eu_pkg::OP_RTI)
                begin
                    p_next = stk_rdata;
                    sp_next = sp_reg + 8'd1;
                    cmd = '{1'b0, 1'b1, sp_next, 8'h00};
                    state_next = S_STEP2;
                end
                else
                begin
                    // RTS low byte
                    lo_next = stk_rdata;
                    sp_next = sp_reg + 8'd1;
                    cmd = '{1'b0, 1'b1, sp_next, 8'h00};
                    state_next = S_STEP3;
                end
            end

            S_STEP2:
            begin
                op = cur_reg.opcode;
                if (cur_reg.req_type || op == c65eu_pkg::OP_BRK)
                begin
                    cmd = '{1'b1, 1'b0, sp_reg,
                            cur_reg.req_type ? (p_reg & ~c65eu_pkg::FLAG_B) : p_reg};
                    sp_next = sp_reg - 8'd1;
                    p_next = p_reg | c65eu_pkg::FLAG_I;
                    pc_next = cur_reg.req_type ? nmi_vector : irq_vector;
                    emit = 1'b1;
                    state_next = S_RUN;
                end
                else
                begin
                    // RTI low byte, then high
                    lo_next = stk_rdata;
                    sp_next = sp_reg + 8'd1;
                    cmd = '{1'b0, 1'b1, sp_next, 8'h00};
                    state_next = S_STEP3;
                end
            end

            S_STEP3:
            begin
                t = {stk_rdata, lo_reg};
                pc_next = (cur_reg.opcode == c65eu_pkg::OP_RTS) ? t + 16'd1 : t;
                emit = 1'b1;
                state_next = S_RUN;
            end

            default: state_next = S_RUN;
        endcase

        if (state_reg != S_RUN && emit)
        begin
            rdata_next.write_address = 16'h0000;
            rdata_next.write_data = 8'h00;
        end
        else if (state_reg != S_RUN)
        begin
            rdata_next.mem_write = rdata_reg.mem_write;
        end

        if (emit)
        begin
            rvalid_next = 1'b1;
            rdata_next.next_pc    = pc_next;
            rdata_next.acc_out    = a_next;
            rdata_next.x_out      = x_next;
            rdata_next.y_out      = y_next;
            rdata_next.status_out = p_next;
            rdata_next.sp_out     = sp_next;
        end
        else if (!(state_reg == S_RUN && accept))
        begin
            rdata_next.mem_write = rdata_reg.mem_write;
        end

        if (pc_load)
        begin
            pc_next = pc_load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RUN;
            a_reg      <= 8'h00;
            x_reg      <= 8'h00;
            y_reg      <= 8'h00;
            p_reg      <= 8'h00;
            sp_reg     <= 8'hFF;
            pc_reg     <= 16'h0000;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            a_reg      <= a_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            p_reg      <= p_next;
            sp_reg     <= sp_next;
            pc_reg     <= pc_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        lo_reg    <= lo_next;
        rdata_reg <= rdata_next;
    end

endmodule

@@ design/cpu6502_execute_unit.sv @@
// Top level of the 6502 execute unit: APB register block, sequencer and stack store.
//
// Takes one request per decoded 6502 instruction (or NMI) and returns one
// result with the architectural registers after it and an optional memory
// write. Most instructions finish in S_RUN, so requests flow back to back;
// JSR, PLA and PLP add S_STEP1, BRK and NMI S_STEP1-2, RTS S_STEP1 and 3, RTI
// S_STEP1-3, with the input held off, set by the single port of the 256-byte
// stack store: one push or registered pull per cycle. The output register lets
// a new request enter in the same cycle as the waiting result is taken; a
// result that is held back holds off the input. Vectors are written over
// the APB port (reset vector at 0x0, IRQ at 0x4, NMI at 0x8); writing the
// reset vector also loads PC. Write registers only while the unit is idle.
module cpu6502_execute_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    c65eu_req_if.sink                         in_req,
    c65eu_res_if.source                       out_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c65eu_pkg::APB_AW-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [15:0] reset_vec_reg, irq_vec_reg, nmi_vec_reg;
    logic        wr_stb;
    c65eu_pkg::stk_cmd_t stk_cmd;
    logic [7:0]  stk_rdata;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_vec_reg <= 16'h0000;
            irq_vec_reg   <= 16'h0000;
            nmi_vec_reg   <= 16'h0000;
        end
        else if (wr_stb)
        begin
            case (paddr)
                c65eu_pkg::ADDR_RESET_VEC: reset_vec_reg <= pwdata[15:0];
                c65eu_pkg::ADDR_IRQ_VEC:   irq_vec_reg   <= pwdata[15:0];
                c65eu_pkg::ADDR_NMI_VEC:   nmi_vec_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            c65eu_pkg::ADDR_RESET_VEC: prdata = {16'h0000, reset_vec_reg};
            c65eu_pkg::ADDR_IRQ_VEC:   prdata = {16'h0000, irq_vec_reg};
            c65eu_pkg::ADDR_NMI_VEC:   prdata = {16'h0000, nmi_vec_reg};
            default:                   prdata = 32'h0000_0000;
        endcase
    end

    c65eu_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (in_req),
        .res           (out_res),
        .pc_load       (wr_stb && (paddr == c65eu_pkg::ADDR_RESET_VEC)),
        .pc_load_value (pwdata[15:0]),
        .irq_vector    (irq_vec_reg),
        .nmi_vector    (nmi_vec_reg),
        .stk_cmd       (stk_cmd),
        .stk_rdata     (stk_rdata)
    );

    c65eu_stack_ram u_stack
    (
        .clk   (clk),
        .cmd   (stk_cmd),
        .rdata (stk_rdata)
    );

endmodule

@@ tb/tb_cpu6502_execute_unit.sv @@
// Self-checking testbench of the 6502 execute unit with its own instruction predictor.
`timescale 1ns / 100ps

module tb_cpu6502_execute_unit;
    import c65eu_pkg::*;

    localparam int TOTAL_RANDOM = 1600;
    localparam int CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    c65eu_req_if in_req ();
    c65eu_res_if out_res ();

    cpu6502_execute_unit DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req.sink),
        .out_res (out_res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: the architectural registers and a shadow of the stack store
    logic [15:0] vec_reset, vec_irq, vec_nmi;
    logic [7:0]  p_a, p_x, p_y, p_sr, p_sp;
    logic [15:0] p_pc;
    logic [7:0]  p_stack [0:255];
    // Tracks which stack entries hold a written value, so no pull reads junk
    bit          stack_valid [0:255];

    req_t   pending_reqs [$];
    res_t   expected_results [$];
    int     mismatches;
    int     results_seen;
    int     cycle_count;
    bit     idle_enabled;
    int     src_gap;
    int     snk_gap;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] nz_update(input logic [7:0] sr, input logic [7:0] v);
        logic [7:0] s;
        s = sr & ~(FLAG_N | FLAG_Z);
        if (v[7])
        begin
            s = s | FLAG_N;
        end
        if (v == 8'h00)
        begin
            s = s | FLAG_Z;
        end
        return s;
    endfunction

    task automatic push_shadow(input logic [7:0] v);
        p_stack[p_sp]     = v;
        stack_valid[p_sp] = 1'b1;
        p_sp              = p_sp - 8'd1;
    endtask

    task automatic pull_shadow(output logic [7:0] v);
        p_sp = p_sp + 8'd1;
        v    = p_stack[p_sp];
    endtask

    task automatic add_binary(input logic [7:0] m);
        logic [8:0] sum;
        sum  = {1'b0, p_a} + {1'b0, m} + {8'd0, p_sr[0]};
        p_sr = sum[8] ? (p_sr | FLAG_C) : (p_sr & ~FLAG_C);
        if ((~(p_a ^ m) & (p_a ^ sum[7:0]) & 8'h80) != 0)
        begin
            p_sr = p_sr | FLAG_V;
        end
        else
        begin
            p_sr = p_sr & ~FLAG_V;
        end
        p_a  = sum[7:0];
        p_sr = nz_update(p_sr, p_a);
    endtask

    task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
        p_sr = (r >= m) ? (p_sr | FLAG_C) : (p_sr & ~FLAG_C);
        p_sr = nz_update(p_sr, r - m);
    endtask

    // Work out the result of one request and advance the predicted state
    task automatic execute_request(input req_t rq, output res_t rs);
        logic [7:0]  m, v, r, lo, hi;
        logic [15:0] seq, npc, t;
        bit          is_acc, take, branch, c;
        opcode_t     op;
        m      = rq.operand_value;
        is_acc = (rq.mode_sel == MODE_ACC);
        seq    = p_pc + {14'd0, rq.inst_size};
        npc    = seq;
        take   = 0;
        branch = 0;
        rs     = '0;
        op     = opcode_t'(rq.opcode);
        if (rq.req_type)
        begin
            push_shadow(p_pc[15:8]);
            push_shadow(p_pc[7:0]);
            push_shadow(p_sr & ~FLAG_B);
            p_sr = p_sr | FLAG_I;
            npc  = vec_nmi;
        end
        else if (rq.opcode <= OP_TYA)
        begin
            case (op)
                OP_ADC: add_binary(m);
                OP_AND:
                begin
                    p_a  = p_a & m;
                    p_sr = nz_update(p_sr, p_a);
                end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR:
                begin
                    v = is_acc ? p_a : m;
                    case (op)
                        OP_ASL:
                        begin
                            c = v[7];
                            r = v << 1;
                        end
                        OP_LSR:
                        begin
                            c = v[0];
                            r = v >> 1;
                        end
                        OP_ROL:
                        begin
                            c = v[7];
                            r = {v[6:0], p_sr[0]};
                        end
                        default:
                        begin
                            c = v[0];
                            r = {p_sr[0], v[7:1]};
                        end
                    endcase
                    p_sr = c ? (p_sr | FLAG_C) : (p_sr & ~FLAG_C);
                    p_sr = nz_update(p_sr, r);
                    if (is_acc)
                    begin
                        p_a = r;
                    end
                    else
                    begin
                        rs.mem_write     = 1'b1;
                        rs.write_address = rq.operand_address;
                        rs.write_data    = r;
                    end
                end
                OP_BCC:
                begin
                    branch = 1;
                    take   = !p_sr[0];
                end
                OP_BCS:
                begin
                    branch = 1;
                    take   = p_sr[0];
                end
                OP_BEQ:
                begin
                    branch = 1;
                    take   = p_sr[1];
                end
                OP_BIT:
                begin
                    p_sr = (p_sr & ~(FLAG_N | FLAG_V | FLAG_Z)) | (m & (FLAG_N | FLAG_V));
                    if ((m & p_a) == 0)
                    begin
                        p_sr = p_sr | FLAG_Z;
                    end
                end
                OP_BMI:
                begin
                    branch = 1;
                    take   = p_sr[7];
                end
                OP_BNE:
                begin
                    branch = 1;
                    take   = !p_sr[1];
                end
                OP_BPL:
                begin
                    branch = 1;
                    take   = !p_sr[7];
                end
                OP_BRK:
                begin
                    t    = p_pc + 16'd2;
                    p_sr = p_sr | FLAG_B;
                    push_shadow(t[15:8]);
                    push_shadow(t[7:0]);
                    push_shadow(p_sr);
                    p_sr = p_sr | FLAG_I;
                    npc  = vec_irq;
                end
                OP_BVC:
                begin
                    branch = 1;
                    take   = !p_sr[6];
                end
                OP_BVS:
                begin
                    branch = 1;
                    take   = p_sr[6];
                end
                OP_CLC: p_sr = p_sr & ~FLAG_C;
                OP_CLD: p_sr = p_sr & ~FLAG_D;
                OP_CLI: p_sr = p_sr & ~FLAG_I;
                OP_CLV: p_sr = p_sr & ~FLAG_V;
                OP_CMP: compare_reg(p_a, m);
                OP_CPX: compare_reg(p_x, m);
                OP_CPY: compare_reg(p_y, m);
                OP_DEC, OP_INC:
                begin
                    r                = (op == OP_DEC) ? m - 8'd1 : m + 8'd1;
                    p_sr             = nz_update(p_sr, r);
                    rs.mem_write     = 1'b1;
                    rs.write_address = rq.operand_address;
                    rs.write_data    = r;
                end
                OP_DEX:
                begin
                    p_x  = p_x - 8'd1;
                    p_sr = nz_update(p_sr, p_x);
                end
                OP_DEY:
                begin
                    p_y  = p_y - 8'd1;
                    p_sr = nz_update(p_sr, p_y);
                end
                OP_EOR:
                begin
                    p_a  = p_a ^ m;
                    p_sr = nz_update(p_sr, p_a);
                end
                OP_INX:
                begin
                    p_x  = p_x + 8'd1;
                    p_sr = nz_update(p_sr, p_x);
                end
                OP_INY:
                begin
                    p_y  = p_y + 8'd1;
                    p_sr = nz_update(p_sr, p_y);
                end
                OP_JMP: npc = rq.operand_address;
                OP_JSR:
                begin
                    t = seq - 16'd1;
                    push_shadow(t[15:8]);
                    push_shadow(t[7:0]);
                    npc = rq.operand_address;
                end
                OP_LDA:
                begin
                    p_a  = m;
                    p_sr = nz_update(p_sr, p_a);
                end
                OP_LDX:
                begin
                    p_x  = m;
                    p_sr = nz_update(p_sr, p_x);
                end
                OP_LDY:
                begin
                    p_y  = m;
                    p_sr = nz_update(p_sr, p_y);
                end
                OP_ORA:
                begin
                    p_a  = p_a | m;
                    p_sr = nz_update(p_sr, p_a);
                end
                OP_PHA: push_shadow(p_a);
                OP_PHP: push_shadow(p_sr | FLAG_B);
                OP_PLA:
                begin
                    pull_shadow(p_a);
                    p_sr = nz_update(p_sr, p_a);
                end
                OP_PLP: pull_shadow(p_sr);
                OP_RTI:
                begin
                    pull_shadow(p_sr);
                    pull_shadow(lo);
                    pull_shadow(hi);
                    npc = {hi, lo};
                end
                OP_RTS:
                begin
                    pull_shadow(lo);
                    pull_shadow(hi);
                    npc = {hi, lo} + 16'd1;
                end
                OP_SBC: add_binary(~m);
                OP_SEC: p_sr = p_sr | FLAG_C;
                OP_SED: p_sr = p_sr | FLAG_D;
                OP_SEI: p_sr = p_sr | FLAG_I;
                OP_STA:
                begin
                    rs.mem_write     = 1'b1;
                    rs.write_address = rq.operand_address;
                    rs.write_data    = p_a;
                end
                OP_STX:
                begin
                    rs.mem_write     = 1'b1;
                    rs.write_address = rq.operand_address;
                    rs.write_data    = p_x;
                end
                OP_STY:
                begin
                    rs.mem_write     = 1'b1;
                    rs.write_address = rq.operand_address;
                    rs.write_data    = p_y;
                end
                OP_TAX:
                begin
                    p_x  = p_a;
                    p_sr = nz_update(p_sr, p_x);
                end
                OP_TAY:
                begin
                    p_y  = p_a;
                    p_sr = nz_update(p_sr, p_y);
                end
                OP_TSX:
                begin
                    p_x  = p_sp;
                    p_sr = nz_update(p_sr, p_x);
                end
                OP_TXA:
                begin
                    p_a  = p_x;
                    p_sr = nz_update(p_sr, p_a);
                end
                OP_TXS: p_sp = p_x;
                OP_TYA:
                begin
                    p_a  = p_y;
                    p_sr = nz_update(p_sr, p_a);
                end
                default: ;
            endcase
            // Sign-extend the branch offset on top of the sequential PC
            if (branch && take)
            begin
                npc = seq + {{8{m[7]}}, m};
            end
        end
        p_pc          = npc;
        rs.next_pc    = p_pc;
        rs.acc_out    = p_a;
        rs.x_out      = p_x;
        rs.y_out      = p_y;
        rs.status_out = p_sr;
        rs.sp_out     = p_sp;
    endtask

    // Report whether a request would pull only stack entries already written
    function automatic bit pulls_are_safe(input req_t rq);
        int n;
        n = 0;
        if (!rq.req_type)
        begin
            case (rq.opcode)
                OP_PLA, OP_PLP: n = 1;
                OP_RTS:         n = 2;
                OP_RTI:         n = 3;
                default:        n = 0;
            endcase
        end
        for (int k = 1; k <= n; k++)
        begin
            if (!stack_valid[8'(p_sp + k)])
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    // Queue one request, predicting it at once; drop it if it would pull junk
    task automatic queue_request(input req_t rq);
        res_t rs;
        if (pulls_are_safe(rq))
        begin
            execute_request(rq, rs);
            pending_reqs.push_back(rq);
            expected_results.push_back(rs);
        end
    endtask

    function automatic req_t make_request(input bit nmi, input logic [5:0] op,
                                          input logic [1:0] mode, input logic [7:0] val);
        req_t rq;
        rq.req_type        = nmi;
        rq.opcode          = op;
        rq.mode_sel        = mode;
        rq.operand_value   = val;
        rq.operand_address = 16'($urandom);
        rq.inst_size       = 2'($urandom_range(1, 3));
        return rq;
    endfunction

    function automatic req_t random_request();
        req_t rq;
        int   pick;
        pick = $urandom_range(0, 99);
        rq   = make_request(1'b0, 6'($urandom_range(0, 55)), 2'($urandom_range(0, 2)),
                            8'($urandom));
        if (pick < 3)
        begin
            rq.req_type = 1'b1;
        end
        else if (pick < 6)
        begin
            // Unused opcode codes, mode 3 and size 0 are all legal corner cases
            rq.opcode    = 6'($urandom_range(56, 63));
            rq.mode_sel  = 2'($urandom_range(0, 3));
            rq.inst_size = 2'($urandom_range(0, 3));
        end
        else if (pick < 10)
        begin
            rq.mode_sel  = 2'd3;
            rq.inst_size = 2'($urandom_range(0, 3));
        end
        return rq;
    endfunction

    // Idle all senders and let the unit drain, then write one register over APB
    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [15:0] value);
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (6) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_RESET_VEC:
            begin
                vec_reset = value;
                p_pc      = value;
            end
            ADDR_IRQ_VEC: vec_irq = value;
            default:      vec_nmi = value;
        endcase
    endtask

    task automatic set_vectors(input logic [15:0] rv, input logic [15:0] iv,
                               input logic [15:0] nv);
        write_register(ADDR_RESET_VEC, rv);
        write_register(ADDR_IRQ_VEC, iv);
        write_register(ADDR_NMI_VEC, nv);
    endtask

    // Driver: present the head of the queue, hold it until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_req.valid   <= 1'b0;
            in_req.payload <= '0;
            src_gap        <= 0;
        end
        else
        begin
            if (in_req.valid && in_req.ready)
            begin
                void'(pending_reqs.pop_front());
            end
            if (in_req.valid && !in_req.ready)
            begin
                // hold the current request
            end
            else if (src_gap > 0)
            begin
                in_req.valid <= 1'b0;
                src_gap      <= src_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                if (idle_enabled && $urandom_range(0, 9) == 0)
                begin
                    in_req.valid <= 1'b0;
                    src_gap      <= $urandom_range(0, 4);
                end
                else
                begin
                    in_req.valid   <= 1'b1;
                    in_req.payload <= pending_reqs[0];
                end
            end
            else
            begin
                in_req.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result side in bursts and check every accepted result
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            out_res.ready <= 1'b0;
            snk_gap       <= 0;
        end
        else
        begin
            if (out_res.valid && out_res.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("Unexpected result %h", out_res.payload);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_res.payload !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                        begin
                            $display("Mismatch: pc %h/%h a %h/%h x %h/%h y %h/%h sr %h/%h",
                                     want.next_pc, out_res.payload.next_pc,
                                     want.acc_out, out_res.payload.acc_out,
                                     want.x_out, out_res.payload.x_out,
                                     want.y_out, out_res.payload.y_out,
                                     want.status_out, out_res.payload.status_out);
                            $display("  sp %h/%h wr %b/%b addr %h/%h data %h/%h",
                                     want.sp_out, out_res.payload.sp_out,
                                     want.mem_write, out_res.payload.mem_write,
                                     want.write_address, out_res.payload.write_address,
                                     want.write_data, out_res.payload.write_data);
                        end
                    end
                end
            end
            if (snk_gap > 0)
            begin
                out_res.ready <= 1'b0;
                snk_gap       <= snk_gap - 1;
            end
            else if (idle_enabled && $urandom_range(0, 9) == 0)
            begin
                out_res.ready <= 1'b0;
                snk_gap       <= $urandom_range(0, 4);
            end
            else
            begin
                out_res.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int   n;
        req_t rq;
        clk          = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        results_seen = 0;
        cycle_count  = 0;
        idle_enabled = 1'b1;
        vec_reset    = 16'h0000;
        vec_irq      = 16'h0000;
        vec_nmi      = 16'h0000;
        p_a          = 8'h00;
        p_x          = 8'h00;
        p_y          = 8'h00;
        p_sr         = 8'h00;
        p_sp         = 8'hFF;
        p_pc         = 16'h0000;
        for (int k = 0; k < 256; k++)
        begin
            p_stack[k]     = 8'h00;
            stack_valid[k] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, flags, stack order, NMI, odd codes
        set_vectors(16'hFFFF, 16'h0000, 16'h8000);
        queue_request(make_request(1'b0, OP_LDA, MODE_IMM, 8'hFF));
        queue_request(make_request(1'b0, OP_ADC, MODE_IMM, 8'h01));
        queue_request(make_request(1'b0, OP_ADC, MODE_IMM, 8'h7F));
        queue_request(make_request(1'b0, OP_SBC, MODE_IMM, 8'h80));
        queue_request(make_request(1'b0, OP_ASL, 2'd0, 8'h81));
        queue_request(make_request(1'b0, OP_LSR, MODE_IMM, 8'hFF));
        queue_request(make_request(1'b0, OP_ROR, MODE_ACC, 8'h00));
        queue_request(make_request(1'b0, OP_BIT, 2'd0, 8'hC0));
        queue_request(make_request(1'b0, OP_BVS, MODE_IMM, 8'h80));
        queue_request(make_request(1'b0, OP_BMI, MODE_IMM, 8'h7F));
        queue_request(make_request(1'b0, OP_JSR, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_PHP, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_PLP, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_RTS, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_BRK, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_RTI, 2'd0, 8'h00));
        queue_request(make_request(1'b1, OP_NOP, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_RTI, 2'd0, 8'h00));
        queue_request(make_request(1'b0, 6'd63, 2'd3, 8'hAA));
        rq           = make_request(1'b0, 6'd56, 2'd0, 8'h55);
        rq.inst_size = 2'd0;
        queue_request(rq);
        queue_request(make_request(1'b0, OP_LDX, MODE_IMM, 8'h00));
        queue_request(make_request(1'b0, OP_TXS, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_PHA, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_PLA, 2'd0, 8'h00));
        queue_request(make_request(1'b0, OP_STX, 2'd0, 8'h00));

        // Random part in four phases, the later three with new vectors; the last phase runs flat out in its second half
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                1: set_vectors(16'h0000, 16'hFFFF, 16'h0000);
                2: set_vectors(16'($urandom), 16'($urandom), 16'hFFFF);
                3: set_vectors(16'($urandom), 16'h8000, 16'($urandom));
                default: ;
            endcase
            n = 0;
            while (n < TOTAL_RANDOM / 4)
            begin
                rq = random_request();
                // In one case of ten, wrap a random request in a JSR/RTS pair
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_request(make_request(1'b0, OP_JSR, 2'd0, 8'h00));
                    queue_request(random_request());
                    rq = make_request(1'b0, OP_RTS, 2'd0, 8'h00);
                    n  = n + 2;
                end
                queue_request(rq);
                n = n + 1;
                if (phase == 3 && n > TOTAL_RANDOM / 8)
                begin
                    idle_enabled = 1'b0;
                end
                if (pending_reqs.size() > 16)
                begin
                    wait (pending_reqs.size() < 8);
                end
                // Hold off the sender until the unit has drained completely
                if (phase == 1 && n >= 100 && n < 103)
                begin
                    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
                end
            end
        end

        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (20) @(posedge clk);
        $display("Ran %0d results over four vector settings: all opcodes, NMI, odd codes.",
                 results_seen);
        $display("Random bursts of idling on both sides, flat-out traffic at the end.");
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Mismatches: %0d", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
